/* src/hpt_pkg.sv */
// hpt_pkg: widths, register indexes, reset values and action codes
// for the homogeneous point transform unit
// no dependencies
`default_nettype none

package hpt_pkg;

    // fixed point formats
    localparam int COEF_FRAC_BITS  = 12;
    localparam int COORD_FRAC_BITS = 16;
    localparam int COEF_W          = 16;
    localparam int COORD_W         = 32;

    // action field
    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_LINEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_AFFINE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_HOMOG  = 2'd2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int BOT_W      = 4 * COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM  = 3'd6;

    // matrix after reset: x row 0x0010 times z, y row 1.0 times y, z and w rows 1.0 times x
    localparam logic [ROW_W-1:0] RST_ROW0 = 48'h0010_0000_0000;
    localparam logic [ROW_W-1:0] RST_ROW1 = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] RST_ROW2 = 48'h0000_0000_1000;
    localparam logic [BOT_W-1:0] RST_BOT  = 64'h0000_0000_0000_1000;

    // datapath widths
    localparam int PROD_W  = COEF_W + COORD_W;          // coefficient times coordinate
    localparam int DOT_W   = PROD_W + 2;                // sum of up to four products
    localparam int RDOT_W  = DOT_W - COEF_FRAC_BITS;    // rounded row sum
    localparam int TPROD_W = 2 * COORD_W;               // translation times w
    localparam int RTR_W   = TPROD_W - COORD_FRAC_BITS; // rounded translation term
    localparam int TERM_W  = (RTR_W > COORD_W) ? RTR_W : COORD_W;
    localparam int SUM_W   = ((RDOT_W > TERM_W) ? RDOT_W : TERM_W) + 1;

    typedef logic signed [COORD_W-1:0] t_coord;

endpackage

`default_nettype wire

/* src/homogeneous_point_transform_unit.sv */
// homogeneous_point_transform_unit: 4x4 fixed point matrix times point,
// three register stages (multiply, sum and round, translate and saturate)
// depends on hpt_pkg
//
// Usage
//   Input channel i_valid / o_ready carries one point word: action plus
//   x, y, z, w in signed Q16.16. Output channel o_valid / i_ready carries
//   the transformed point and the clipped flag.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata,
//   one register per cycle; the user must write configuration only while
//   no word is in flight, as the block itself does not enforce this.
//   o_valid rises once an accepted word has passed the multiply, the sum
//   and round and the saturate registers.
//   Throughput: one word per cycle while i_ready is high.
//   Stalls: each stage holds its word while the stage after it is full
//   and not draining; empty stages still fill, so the input keeps being
//   accepted until all three stages hold a word. o_ready is low only
//   when the pipeline is full and i_ready is low.
//   Reset (synchronous, active low): pipeline empties, the matrix returns
//   to the hpt_pkg reset rows and the translations to zero.
`default_nettype none

module homogeneous_point_transform_unit
    import hpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ACT_W-1:0]      i_action,
    input  t_coord                i_in_x,
    input  t_coord                i_in_y,
    input  t_coord                i_in_z,
    input  t_coord                i_in_w,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_coord                o_out_x,
    output t_coord                o_out_y,
    output t_coord                o_out_z,
    output t_coord                o_out_w,
    output logic                  o_clipped
);

    localparam logic signed [DOT_W-1:0] RND_COEF =
        DOT_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [TPROD_W-1:0] RND_COORD =
        TPROD_W'(1) <<< (COORD_FRAC_BITS - 1);

    // saturate to a coordinate, msb of the result is the clip flag
    function automatic logic [COORD_W:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic ovf;
        logic [COORD_W-1:0] val;
        ovf = !((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1]));
        if (!ovf) begin
            val = v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            val = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            val = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return {ovf, val};
    endfunction

    // configuration registers
    logic [ROW_W-1:0] r_row [3];
    t_coord           r_shift [3];
    logic [BOT_W-1:0] r_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= RST_ROW0;
            r_row[1]   <= RST_ROW1;
            r_row[2]   <= RST_ROW2;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
            r_bot      <= RST_BOT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW0:    r_row[0]   <= i_cfg_wdata[ROW_W-1:0];
                REG_ROW1:    r_row[1]   <= i_cfg_wdata[ROW_W-1:0];
                REG_ROW2:    r_row[2]   <= i_cfg_wdata[ROW_W-1:0];
                REG_SHIFT_X: r_shift[0] <= i_cfg_wdata[COORD_W-1:0];
                REG_SHIFT_Y: r_shift[1] <= i_cfg_wdata[COORD_W-1:0];
                REG_SHIFT_Z: r_shift[2] <= i_cfg_wdata[COORD_W-1:0];
                REG_BOTTOM:  r_bot      <= i_cfg_wdata[BOT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and advance enables
    logic r_v1, r_v2, r_v3;
    logic s1_en, s2_en, s3_en;

    assign s3_en   = !r_v3 || i_ready;
    assign s2_en   = !r_v2 || s3_en;
    assign s1_en   = !r_v1 || s2_en;
    assign o_ready = s1_en;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_en) begin
                r_v1 <= i_valid;
            end
            if (s2_en) begin
                r_v2 <= r_v1;
            end
            if (s3_en) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: all coefficient and translation products
    t_coord pt [4];
    logic signed [PROD_W-1:0]  n_lin_prod [3][3];
    logic signed [PROD_W-1:0]  n_bot_prod [4];
    logic signed [TPROD_W-1:0] n_tr_prod [3];
    logic signed [PROD_W-1:0]  r_lin_prod [3][3];
    logic signed [PROD_W-1:0]  r_bot_prod [4];
    logic signed [TPROD_W-1:0] r_tr_prod [3];
    logic [ACT_W-1:0]          r_act1;

    assign pt[0] = i_in_x;
    assign pt[1] = i_in_y;
    assign pt[2] = i_in_z;
    assign pt[3] = i_in_w;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_lin_prod[r][c] = $signed(r_row[r][COEF_W*c +: COEF_W]) * pt[c];
            end
            n_tr_prod[r] = r_shift[r] * pt[3];
        end
        for (int c = 0; c < 4; c++) begin
            n_bot_prod[c] = $signed(r_bot[COEF_W*c +: COEF_W]) * pt[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_lin_prod <= n_lin_prod;
            r_bot_prod <= n_bot_prod;
            r_tr_prod  <= n_tr_prod;
            r_act1     <= i_action;
        end
    end

    // stage 2: row sums with rounding, translation term by action
    logic signed [DOT_W-1:0]   n_dot [4];
    logic signed [RDOT_W-1:0]  n_rdot [4];
    logic signed [TPROD_W-1:0] n_tr_rnd [3];
    logic signed [RTR_W-1:0]   n_tr_term [3];
    logic signed [TERM_W-1:0]  n_tsel [3];
    logic                      n_hom;
    logic signed [RDOT_W-1:0]  r_rdot [4];
    logic signed [TERM_W-1:0]  r_tsel [3];
    logic                      r_hom2;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_dot[r] = DOT_W'(r_lin_prod[r][0]) + DOT_W'(r_lin_prod[r][1])
                     + DOT_W'(r_lin_prod[r][2]) + RND_COEF;
        end
        n_dot[3] = DOT_W'(r_bot_prod[0]) + DOT_W'(r_bot_prod[1])
                 + DOT_W'(r_bot_prod[2]) + DOT_W'(r_bot_prod[3]) + RND_COEF;
        for (int r = 0; r < 4; r++) begin
            n_rdot[r] = n_dot[r][DOT_W-1:COEF_FRAC_BITS];
        end
        for (int r = 0; r < 3; r++) begin
            n_tr_rnd[r]  = r_tr_prod[r] + RND_COORD;
            n_tr_term[r] = n_tr_rnd[r][TPROD_W-1:COORD_FRAC_BITS];
            case (r_act1)
                ACT_LINEAR: n_tsel[r] = '0;
                ACT_AFFINE: n_tsel[r] = TERM_W'(r_shift[r]);
                default:    n_tsel[r] = TERM_W'(n_tr_term[r]);
            endcase
        end
        n_hom = (r_act1 != ACT_LINEAR) && (r_act1 != ACT_AFFINE);
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_rdot <= n_rdot;
            r_tsel <= n_tsel;
            r_hom2 <= n_hom;
        end
    end

    // stage 3: add translation, saturate, output register
    logic signed [SUM_W-1:0] n_sum [4];
    logic [COORD_W:0]        n_sat [4];
    t_coord                  r_out [4];
    logic                    r_clip;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = SUM_W'(r_rdot[r]) + SUM_W'(r_tsel[r]);
        end
        n_sum[3] = SUM_W'(r_rdot[3]);
        for (int r = 0; r < 4; r++) begin
            n_sat[r] = sat_word(n_sum[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_en) begin
            r_out[0] <= n_sat[0][COORD_W-1:0];
            r_out[1] <= n_sat[1][COORD_W-1:0];
            r_out[2] <= n_sat[2][COORD_W-1:0];
            r_out[3] <= r_hom2 ? n_sat[3][COORD_W-1:0] : '0;
            r_clip   <= n_sat[0][COORD_W] | n_sat[1][COORD_W] | n_sat[2][COORD_W]
                      | (r_hom2 & n_sat[3][COORD_W]);
        end
    end

    assign o_out_x   = r_out[0];
    assign o_out_y   = r_out[1];
    assign o_out_z   = r_out[2];
    assign o_out_w   = r_out[3];
    assign o_clipped = r_clip;

    // checks
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2 && !r_v3)
        else $error("pipeline not empty after reset");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3)
        else $error("input blocked with an empty stage");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_v3 && !i_ready |=> r_v2 && $stable(r_rdot[3]) && $stable(r_tsel[0]))
        else $error("stage 2 word changed during stall");

    a_three_vector_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_hom2 && s3_en |=> o_out_w == '0)
        else $error("w nonzero for three-vector action");

endmodule

`default_nettype wire

/* dv/hpt_transform_checker.sv */
// hpt_transform_checker: watches the register port and both word channels of the
// point transform unit, predicts each result word and compares it on arrival
// depends on hpt_pkg
module hpt_transform_checker
    import hpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [ACT_W-1:0]      i_action,
    input  t_coord                i_in_x,
    input  t_coord                i_in_y,
    input  t_coord                i_in_z,
    input  t_coord                i_in_w,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_coord                i_out_x,
    input  t_coord                i_out_y,
    input  t_coord                i_out_z,
    input  t_coord                i_out_w,
    input  logic                  i_clipped,
    output int                    o_pending,
    output int                    o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_MAX   = 64'sd2147483647;
    localparam longint COORD_MIN   = -64'sd2147483648;
    localparam int     PRINT_LIMIT = 100;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        t_coord w;
        logic   clip;
    } t_point;

    // shadow copy of the transform registers
    logic [ROW_W-1:0] lin_row [3];
    t_coord           shift [3];
    logic [BOT_W-1:0] bot_row;

    t_point expected_q [$];
    t_point want;
    int     pending = 0;
    int     errors  = 0;

    assign o_pending = pending;
    assign o_errors  = errors;

    // signed coefficient col of a packed row
    function automatic longint coef_of(logic [BOT_W-1:0] row_bits, int col);
        logic signed [COEF_W-1:0] c;
        c = row_bits[col*COEF_W +: COEF_W];
        return longint'(c);
    endfunction

    // round to nearest, ties toward plus infinity, dropping drop fraction bits
    function automatic longint round_off(longint v, int drop);
        return (v + (longint'(1) << (drop - 1))) >>> drop;
    endfunction

    function automatic t_coord clamp(longint v, inout logic clip);
        longint c;
        c = v;
        if (c > COORD_MAX) begin
            c = COORD_MAX;
            clip = 1'b1;
        end
        if (c < COORD_MIN) begin
            c = COORD_MIN;
            clip = 1'b1;
        end
        return c[COORD_W-1:0];
    endfunction

    // expected result word for one point under the current registers
    function automatic t_point transform(logic [ACT_W-1:0] act, t_coord x, t_coord y,
                                         t_coord z, t_coord w);
        longint p [4];
        longint acc;
        longint v;
        logic   clip;
        t_coord row_out [3];
        t_point r;
        p[0] = longint'(x);
        p[1] = longint'(y);
        p[2] = longint'(z);
        p[3] = longint'(w);
        clip = 1'b0;
        for (int k = 0; k < 3; k++) begin
            acc = coef_of(BOT_W'(lin_row[k]), 0) * p[0]
                + coef_of(BOT_W'(lin_row[k]), 1) * p[1]
                + coef_of(BOT_W'(lin_row[k]), 2) * p[2];
            v = round_off(acc, COEF_FRAC_BITS);
            if (act == ACT_AFFINE) begin
                v = v + longint'(shift[k]);
            end else if (act != ACT_LINEAR) begin
                // homogeneous: translation scaled by w, rounded on its own
                v = v + round_off(longint'(shift[k]) * p[3], COORD_FRAC_BITS);
            end
            row_out[k] = clamp(v, clip);
        end
        r.x = row_out[0];
        r.y = row_out[1];
        r.z = row_out[2];
        // three-vector modes give w zero and never clip on it
        if (act != ACT_LINEAR && act != ACT_AFFINE) begin
            acc = coef_of(bot_row, 0) * p[0] + coef_of(bot_row, 1) * p[1]
                + coef_of(bot_row, 2) * p[2] + coef_of(bot_row, 3) * p[3];
            r.w = clamp(round_off(acc, COEF_FRAC_BITS), clip);
        end else begin
            r.w = '0;
        end
        r.clip = clip;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (errors < PRINT_LIMIT) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
        errors++;
    endtask

    task automatic check_field(string name, logic [COORD_W-1:0] got,
                               logic [COORD_W-1:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s got %h, expected %h", name, got, exp_val));
        end
    endtask

    // snoop registers, check result words, predict accepted words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lin_row[0] = RST_ROW0;
            lin_row[1] = RST_ROW1;
            lin_row[2] = RST_ROW2;
            bot_row    = RST_BOT;
            for (int k = 0; k < 3; k++) begin
                shift[k] = '0;
            end
            expected_q.delete();
            pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROW0:    lin_row[0] = i_cfg_wdata[ROW_W-1:0];
                    REG_ROW1:    lin_row[1] = i_cfg_wdata[ROW_W-1:0];
                    REG_ROW2:    lin_row[2] = i_cfg_wdata[ROW_W-1:0];
                    REG_SHIFT_X: shift[0]   = i_cfg_wdata[COORD_W-1:0];
                    REG_SHIFT_Y: shift[1]   = i_cfg_wdata[COORD_W-1:0];
                    REG_SHIFT_Z: shift[2]   = i_cfg_wdata[COORD_W-1:0];
                    REG_BOTTOM:  bot_row    = i_cfg_wdata[BOT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_x", i_out_x, want.x);
                    check_field("out_y", i_out_y, want.y);
                    check_field("out_z", i_out_z, want.z);
                    check_field("out_w", i_out_w, want.w);
                    check_field("clipped", {31'd0, i_clipped}, {31'd0, want.clip});
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(transform(i_action, i_in_x, i_in_y, i_in_z, i_in_w));
            end
            pending <= expected_q.size();
        end
    end

endmodule

/* dv/tb_homogeneous_point_transform_unit.sv */
// tb_homogeneous_point_transform_unit: drives points and register settings into
// the transform unit with random gaps and stalls; the checker does the comparing
// depends on hpt_pkg, homogeneous_point_transform_unit, hpt_transform_checker
module tb_homogeneous_point_transform_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import hpt_pkg::*;

    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 244;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int LONG_HOLD       = 300;

    // unused action code, handled as homogeneous
    localparam logic [ACT_W-1:0]     ACT_SPARE  = 2'd3;
    // unused register index, writes have no effect
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum { SET_GENTLE, SET_HIGH, SET_LOW, SET_ZERO, SET_MIXED } t_coef_set;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_ready;
    logic [ACT_W-1:0]      i_action;
    t_coord                i_in_x;
    t_coord                i_in_y;
    t_coord                i_in_z;
    t_coord                i_in_w;
    logic                  o_valid;
    logic                  i_ready;
    t_coord                o_out_x;
    t_coord                o_out_y;
    t_coord                o_out_z;
    t_coord                o_out_w;
    logic                  o_clipped;

    int pending_words;
    int error_count;
    int cycle_count;
    bit calm     = 1'b0;
    bit hold_off = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    homogeneous_point_transform_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_in_z      (i_in_z),
        .i_in_w      (i_in_w),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_out_w     (o_out_w),
        .o_clipped   (o_clipped)
    );

    hpt_transform_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_action    (i_action),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_in_z      (i_in_z),
        .i_in_w      (i_in_w),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_x     (o_out_x),
        .i_out_y     (o_out_y),
        .i_out_z     (o_out_z),
        .i_out_w     (o_out_w),
        .i_clipped   (o_clipped),
        .o_pending   (pending_words),
        .o_errors    (error_count)
    );

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ACT_W-1:0] action_at(int k);
        case (k)
            0:       return ACT_LINEAR;
            1:       return ACT_AFFINE;
            2:       return ACT_HOMOG;
            default: return ACT_SPARE;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(t_coef_set s);
        logic [COEF_W-1:0] c;
        case (s)
            SET_HIGH:  c = 16'h7FFF;
            SET_LOW:   c = 16'h8000;
            SET_ZERO:  c = '0;
            SET_MIXED: c = COEF_W'($urandom);
            default:   c = COEF_W'($urandom_range(0, 8192) - 4096); // within +-1.0
        endcase
        return c;
    endfunction

    function automatic t_coord pick_shift(t_coef_set s);
        t_coord v;
        case (s)
            SET_HIGH:  v = 32'h7FFF_FFFF;
            SET_LOW:   v = 32'h8000_0000;
            SET_ZERO:  v = '0;
            SET_MIXED: v = $urandom;
            default:   v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
        return v;
    endfunction

    // coordinates: some corner values, many small, the rest full range
    function automatic t_coord pick_coord();
        int     r;
        t_coord v;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 4))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = '0;
                3:       v = 32'hFFFF_FFFF;
                default: v = 32'h0000_0001;
            endcase
        end else if (r < 60) begin
            v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // all registers, unused upper data bits filled with noise
    task automatic program_regs(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                                logic [ROW_W-1:0] r2, t_coord sx, t_coord sy, t_coord sz,
                                logic [BOT_W-1:0] bot);
        logic [15:0] pad16;
        logic [31:0] pad32;
        pad16 = 16'($urandom);
        pad32 = $urandom;
        write_reg(REG_ROW0, {pad16, r0});
        write_reg(REG_ROW1, {~pad16, r1});
        write_reg(REG_ROW2, {pad16 ^ 16'h5A5A, r2});
        write_reg(REG_SHIFT_X, {pad32, sx});
        write_reg(REG_SHIFT_Y, {~pad32, sy});
        write_reg(REG_SHIFT_Z, {pad32 ^ 32'h5A5A_5A5A, sz});
        write_reg(REG_BOTTOM, bot);
        write_reg(REG_UNUSED, {pad32, ~pad32});
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_phase(t_coef_set s);
        program_regs({pick_coef(s), pick_coef(s), pick_coef(s)},
                     {pick_coef(s), pick_coef(s), pick_coef(s)},
                     {pick_coef(s), pick_coef(s), pick_coef(s)},
                     pick_shift(s), pick_shift(s), pick_shift(s),
                     {pick_coef(s), pick_coef(s), pick_coef(s), pick_coef(s)});
    endtask

    // offer one point word and return at the edge that takes it
    task automatic push_point(logic [ACT_W-1:0] act, t_coord x, t_coord y, t_coord z,
                              t_coord w);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_in_x   <= x;
        i_in_y   <= y;
        i_in_z   <= z;
        i_in_w   <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // wait until every predicted word has come out, then let the pipe settle
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_coef_set plan_for(int p);
        case (p)
            1:       return SET_HIGH;
            3:       return SET_LOW;
            5:       return SET_ZERO;
            2, 6:    return SET_MIXED;
            default: return SET_GENTLE;
        endcase
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin : sink
        int n;
        bit held;
        held = 1'b0;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = calm ? 0 : pick_gap();
            if (hold_off && !held) begin
                n = LONG_HOLD;
                held = 1'b1;
            end
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // run limit
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_homogeneous_point_transform_unit: done, errors");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_ROW0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_action    = ACT_LINEAR;
        i_in_x      = '0;
        i_in_y      = '0;
        i_in_z      = '0;
        i_in_w      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset matrix: corner coordinates through every action
        for (int k = 0; k < 4; k++) begin
            push_point(action_at(k), 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
            push_point(action_at(k), 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF);
        end
        drain_pipeline();

        // saturating rows, half coefficients for rounding ties, half shift for w ties
        program_regs({3{16'h7FFF}}, {3{16'h8000}}, 48'h0000_0000_0800,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000,
                     64'h0800_0000_0000_0800);
        for (int k = 0; k < 4; k++) begin
            push_point(action_at(k), 32'h1, 32'h1, 32'h1, 32'h1);
            push_point(action_at(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF);
            push_point(action_at(k), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF);
            push_point(action_at(k), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000);
        end
        drain_pipeline();

        // random phases, one register setting each
        for (int p = 0; p < N_PHASES; p++) begin
            set_phase(plan_for(p));
            calm = (p == 4) || (p == 6);
            if (p == 0) begin
                hold_off = 1'b1;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                push_point(action_at($urandom_range(0, 3)), pick_coord(), pick_coord(),
                           pick_coord(), pick_coord());
            end
            drain_pipeline();
            calm = 1'b0;
        end

        if (error_count == 0) begin
            $display("tb_homogeneous_point_transform_unit: done, clean");
        end else begin
            $display("tb_homogeneous_point_transform_unit: done, errors");
        end
        $finish;
    end

endmodule

/* homogeneous_point_transform_unit.f */
src/hpt_pkg.sv
src/homogeneous_point_transform_unit.sv
dv/hpt_transform_checker.sv
dv/tb_homogeneous_point_transform_unit.sv
